/* sv/lruc_pkg.sv */
// ============================================================================
// lruc_pkg - shared types and constants for the LRU cache cost tracker
// Field widths of the channels and the size setting, and the access costs.
// ============================================================================
`default_nettype none

package lruc_pkg;

    // Channel and size field widths
    localparam int KEY_W  = 64;
    localparam int COST_W = 32;
    localparam int SIZE_W = 6;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [COST_W-1:0] cost_t;
    typedef logic [SIZE_W-1:0] size_t;

    // Access costs and the saturation point of the running total
    localparam cost_t HIT_COST  = cost_t'(1);
    localparam cost_t MISS_COST = cost_t'(5);
    localparam cost_t COST_MAX  = {COST_W{1'b1}};

endpackage

`default_nettype wire

/* sv/lruc_if.sv */
// ============================================================================
// lruc_if - valid/ready channels of the LRU cache cost tracker
// Request channel carries one key; result channel carries hit and total cost.
// ============================================================================
`default_nettype none

interface lruc_req_if;
    logic          valid;
    logic          ready;
    lruc_pkg::key_t key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface lruc_rsp_if;
    logic            valid;
    logic            ready;
    logic            hit;
    lruc_pkg::cost_t total_cost;

    modport source (output valid, output hit, output total_cost, input ready);
    modport sink   (input valid, input hit, input total_cost, output ready);
endinterface

`default_nettype wire

/* sv/lru_cache_hit_cost_tracker_unit.sv */
// ============================================================================
// lru_cache_hit_cost_tracker_unit - fully associative LRU cache with cost sum
// Looks up one key per transfer, evicts the least recently used entry on a
// miss when full, reports the hit flag and a saturating running access cost.
// ============================================================================
// A key transfer is captured in an input register; once the result register
// is free or drained, all CAPACITY entries are compared in parallel, the
// recency ranks, the occupancy count and the cost total are updated, and the
// result is registered. The block sustains one key per cycle: that figure
// is set by the single pass of key compare and rank update over all entries
// between the input register and the state registers, and it holds as long as
// the result side takes each result. Hits add 1 and misses add 5 to the total,
// which sticks at its maximum. A cache_size of 0 makes every access a miss and
// leaves the entries untouched; values above CAPACITY act as CAPACITY; lowering
// it does not flush, each later miss evicts one entry. Write cache_size only
// while no key is in flight. No clearing pass is needed after reset.
`default_nettype none

module lru_cache_hit_cost_tracker_unit #(
    parameter int CAPACITY = 32,
    parameter int KEY_BITS = 64
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire lruc_pkg::size_t  cfg_wdata,
    lruc_req_if.sink              req,
    lruc_rsp_if.source            rsp
);
    import lruc_pkg::*;

    localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    typedef logic [RANK_W-1:0]   rank_t;
    typedef logic [KEY_BITS-1:0] tag_t;

    // Configuration and bookkeeping registers
    size_t                cache_size_reg;
    logic                 s1_valid_reg;
    tag_t                 s1_key_reg;
    logic                 out_valid_reg;
    logic                 out_hit_reg;
    cost_t                cost_sum_reg, cost_sum_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CAPACITY-1:0]  valid_reg, valid_next;
    rank_t                rank_reg  [CAPACITY];
    rank_t                rank_next [CAPACITY];
    tag_t                 keys_reg  [CAPACITY];

    // Handshake: the lookup stage moves when the result slot is free or drained
    logic                 advance;
    logic                 fire;

    // Lookup signals
    logic [CMP_W-1:0]     size_eff;
    logic                 size_nz;
    logic [CAPACITY-1:0]  match;
    logic                 hit;
    rank_t                hit_rank;
    logic [CNT_W-1:0]     count_m1;
    logic [CAPACITY-1:0]  victim;
    logic                 evict;
    logic [CAPACITY-1:0]  valid_after;
    logic [CAPACITY-1:0]  slot_oh;
    cost_t                cost_add;

    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.total_cost = cost_sum_reg;

    // Effective size, clamped to the number of entries
    always_comb
    begin
        if (CMP_W'(cache_size_reg) > CMP_W'(CAPACITY))
            size_eff = CMP_W'(CAPACITY);
        else
            size_eff = CMP_W'(cache_size_reg);
        size_nz = (cache_size_reg != '0);
    end

    // Parallel compare, victim select and free slot
    always_comb
    begin
        hit_rank = '0;
        count_m1 = count_reg - CNT_W'(1);
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i]  = valid_reg[i] && (keys_reg[i] == s1_key_reg);
            victim[i] = valid_reg[i] && (rank_reg[i] == count_m1[RANK_W-1:0]);
            hit_rank  = hit_rank | (match[i] ? rank_reg[i] : '0);
        end
        hit         = size_nz && (|match);
        evict       = size_nz && !hit && (CMP_W'(count_reg) >= size_eff);
        valid_after = valid_reg & ~(evict ? victim : '0);
        // lowest clear bit of the occupancy after eviction
        slot_oh     = ~valid_after & (valid_after + CAPACITY'(1));
    end

    // Next state of ranks, valid bits and count
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < CAPACITY; i++)
            rank_next[i] = rank_reg[i];

        if (fire && size_nz)
        begin
            if (hit)
            begin
                // promote the hit entry, age the ones that were more recent
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (match[i])
                        rank_next[i] = '0;
                    else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            else
            begin
                // age all survivors, insert the new key as most recent
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (slot_oh[i])
                        rank_next[i] = '0;
                    else if (valid_after[i])
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
                valid_next = valid_after | slot_oh;
                if (!evict)
                    count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // Saturating cost total
    always_comb
    begin
        cost_add      = hit ? HIT_COST : MISS_COST;
        cost_sum_next = cost_sum_reg;
        if (fire)
        begin
            if (cost_sum_reg > (COST_MAX - cost_add))
                cost_sum_next = COST_MAX;
            else
                cost_sum_next = cost_sum_reg + cost_add;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_size_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_hit_reg    <= 1'b0;
            cost_sum_reg   <= '0;
            count_reg      <= '0;
            valid_reg      <= '0;
            for (int i = 0; i < CAPACITY; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                cache_size_reg <= cfg_wdata;
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
            if (fire)
                out_hit_reg <= hit;
            cost_sum_reg <= cost_sum_next;
            count_reg    <= count_next;
            valid_reg    <= valid_next;
            for (int i = 0; i < CAPACITY; i++)
                rank_reg[i] <= rank_next[i];
        end
    end

    // Payload registers: captured key and stored tags
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            s1_key_reg <= req.key[KEY_BITS-1:0];
        if (fire && size_nz && !hit)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (slot_oh[i])
                    keys_reg[i] <= s1_key_reg;
            end
        end
    end

endmodule

`default_nettype wire

/* test/lru_cache_hit_cost_tracker_unit_test.sv */
// ============================================================================
// lru_cache_hit_cost_tracker_unit_test - self-checking bench for the LRU cache
// Sends keys through the request channel in random bursts and checks each hit
// flag and running cost against a behavioral LRU cache model kept in the
// bench. The cache size is changed between phases, covering size zero, sizes
// above capacity and shrinking a filled cache. The receiver stalls at random
// and once holds off long enough to back up the block.
// ============================================================================
`default_nettype none

module lru_cache_hit_cost_tracker_unit_test;
    import lruc_pkg::*;

    localparam int CAPACITY    = 32;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 250;
    localparam int HOLD_AFTER  = 400;

    typedef struct packed {
        logic  hit;
        cost_t total_cost;
    } access_rsp_t;

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    size_t cfg_wdata;

    lruc_req_if req_ch ();
    lruc_rsp_if rsp_ch ();

    lru_cache_hit_cost_tracker_unit #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Cache model state
    key_t        cache_key  [CAPACITY];
    bit          cache_vld  [CAPACITY];
    int unsigned cache_rank [CAPACITY];
    cost_t       cost_total;
    size_t       size_cfg;

    key_t        key_q [$];
    access_rsp_t expected_rsp_q [$];
    int          n_err;
    int          n_results;

    // Saturating add to the running cost
    function automatic void charge(cost_t c);
        if (cost_total > COST_MAX - c)
            cost_total = COST_MAX;
        else
            cost_total = cost_total + c;
    endfunction

    // One lookup: update the model cache and return the expected result
    function automatic access_rsp_t lru_access(key_t k);
        access_rsp_t r;
        int          eff;
        int          found;
        int          count;
        int          victim;
        int          slot;
        int unsigned fr;
        eff    = (size_cfg > CAPACITY) ? CAPACITY : int'(size_cfg);
        found  = -1;
        count  = 0;
        victim = -1;
        slot   = -1;
        r.hit  = 1'b0;
        if (eff == 0)
        begin
            charge(MISS_COST);
        end
        else
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (cache_vld[i])
                begin
                    count++;
                    if (cache_key[i] == k)
                        found = i;
                end
            end
            if (found >= 0)
            begin
                // hit: everything more recent than the entry ages by one
                fr = cache_rank[found];
                for (int i = 0; i < CAPACITY; i++)
                    if (cache_vld[i] && cache_rank[i] < fr)
                        cache_rank[i]++;
                cache_rank[found] = 0;
                r.hit = 1'b1;
                charge(HIT_COST);
            end
            else
            begin
                // miss: evict one LRU entry when full, then insert
                if (count >= eff)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (cache_vld[i] && (victim < 0 || cache_rank[i] > cache_rank[victim]))
                            victim = i;
                    if (victim >= 0)
                        cache_vld[victim] = 1'b0;
                end
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (cache_vld[i])
                        cache_rank[i]++;
                    else if (slot < 0)
                        slot = i;
                end
                if (slot >= 0)
                begin
                    cache_key[slot]  = k;
                    cache_vld[slot]  = 1'b1;
                    cache_rank[slot] = 0;
                end
                charge(MISS_COST);
            end
        end
        r.total_cost = cost_total;
        return r;
    endfunction

    // Request driver: bursts of transfers separated by random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk)
    begin
        logic take;
        logic nxt_valid;
        int   pick;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            take = req_ch.valid && req_ch.ready;
            if (take)
            begin
                expected_rsp_q.push_back(lru_access(req_ch.key));
                key_q.delete(0);
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                        gap_left = 0;
                    else if (pick < 8)
                        gap_left = $urandom_range(1, 4);
                    else
                        gap_left = $urandom_range(5, 20);
                    burst_left = $urandom_range(1, 40);
                end
            end
            if (req_ch.valid && !take)
            begin
                nxt_valid = 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                nxt_valid = 1'b0;
            end
            else if (key_q.size() > 0)
            begin
                nxt_valid = 1'b1;
                req_ch.key <= key_q[0];
            end
            else
            begin
                nxt_valid = 1'b0;
            end
            req_ch.valid <= nxt_valid;
        end
    end

    // Result receiver: stall pattern per window, plus one long hold-off
    int         hold_left;
    bit         hold_done;
    int         win_left;
    int         rdy_mode;
    logic [7:0] stall_pat;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
            win_left  = 0;
            rdy_mode  = 0;
            stall_pat = 8'hff;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (!hold_done && n_results >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (win_left == 0)
            begin
                rdy_mode  = $urandom_range(0, 3);
                win_left  = $urandom_range(16, 96);
                stall_pat = 8'($urandom);
            end
            else
            begin
                win_left--;
            end
            stall_pat = {stall_pat[6:0], stall_pat[7]};
            case (rdy_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                2:       rsp_ch.ready <= stall_pat[0];
                default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        access_rsp_t exp_r;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            n_results++;
            if (expected_rsp_q.size() == 0)
            begin
                $error("unexpected result transfer: hit=%0b total_cost=%0d",
                       rsp_ch.hit, rsp_ch.total_cost);
                n_err++;
            end
            else
            begin
                exp_r = expected_rsp_q.pop_front();
                if (rsp_ch.hit !== exp_r.hit)
                begin
                    $error("hit: expected %0b, got %0b", exp_r.hit, rsp_ch.hit);
                    n_err++;
                end
                if (rsp_ch.total_cost !== exp_r.total_cost)
                begin
                    $error("total_cost: expected %0d, got %0d",
                           exp_r.total_cost, rsp_ch.total_cost);
                    n_err++;
                end
            end
        end
    end

    // Watchdog
    int cyc;

    always @(posedge clk)
    begin
        cyc++;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("lru_cache_hit_cost_tracker_unit_test NOT OK");
            $finish;
        end
    end

    // Wait until every key is sent and every result has come back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (key_q.size() != 0 || req_ch.valid || expected_rsp_q.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_size(size_t v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        size_cfg = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic key_t rand_key();
        return {$urandom, $urandom};
    endfunction

    // One phase: new size, a key pool scaled to it, mostly pool hits
    task automatic run_phase(size_t sz, int n_items);
        key_t pool [$];
        int   eff;
        int   psz;
        int   pick;
        key_t k;
        write_size(sz);
        eff = (sz > CAPACITY) ? CAPACITY : int'(sz);
        psz = $urandom_range(1, eff + eff / 2 + 2);
        for (int i = 0; i < psz; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2 && i > 0)
                pool.push_back(pool[i - 1] ^ (key_t'(1) << $urandom_range(0, KEY_W - 1)));
            else if (pick == 2)
                pool.push_back($urandom_range(0, 1) ? '0 : '1);
            else
                pool.push_back(rand_key());
        end
        @(negedge clk);
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                k = rand_key();
            else if (pick < 12)
                k = pool[$urandom_range(0, psz - 1)] ^
                    (key_t'(1) << $urandom_range(0, KEY_W - 1));
            else if (pick < 14)
                k = $urandom_range(0, 1) ? '0 : '1;
            else
                k = pool[$urandom_range(0, psz - 1)];
            key_q.push_back(k);
        end
        wait_idle();
    endtask

    // Main sequence
    initial
    begin
        size_t sizes [12];
        sizes = '{6'd32, 6'd3, 6'd63, 6'd1, 6'd0, 6'd16, 6'd33, 6'd2, 6'd32, 6'd8, 6'd5, 6'd0};
        sizes[11] = size_t'($urandom_range(0, 63));

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        req_ch.valid = 1'b0;
        req_ch.key   = '0;
        rsp_ch.ready = 1'b0;
        n_err        = 0;
        n_results    = 0;
        cyc          = 0;
        size_cfg     = '0;
        cost_total   = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            cache_key[i]  = '0;
            cache_vld[i]  = 1'b0;
            cache_rank[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // size zero out of reset: everything misses
        @(negedge clk);
        key_q.push_back('0);
        key_q.push_back('1);
        key_q.push_back('0);
        wait_idle();

        // two entries: hits, LRU eviction, keys one bit apart
        write_size(6'd2);
        @(negedge clk);
        key_q.push_back('0);
        key_q.push_back('1);
        key_q.push_back('0);
        key_q.push_back(64'h8000_0000_0000_0000);
        key_q.push_back('1);
        key_q.push_back(64'h8000_0000_0000_0000);
        key_q.push_back('0);
        key_q.push_back(64'h0000_0000_0000_0001);
        key_q.push_back('0);
        key_q.push_back(64'h7fff_ffff_ffff_ffff);
        key_q.push_back('1);
        wait_idle();

        // random phases; a full cache followed by size 3 shrinks it
        foreach (sizes[i])
            run_phase(sizes[i], $urandom_range(90, 140));

        wait_idle();
        repeat (5) @(posedge clk);
        if (n_err == 0 && expected_rsp_q.size() == 0)
            $display("lru_cache_hit_cost_tracker_unit_test OK");
        else
            $display("lru_cache_hit_cost_tracker_unit_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
sv/lruc_pkg.sv
sv/lruc_if.sv
sv/lru_cache_hit_cost_tracker_unit.sv
test/lru_cache_hit_cost_tracker_unit_test.sv
